// File: hdl/mnpt_pkg.sv
// shared types, command codes and defaults for the midi note pairing table
// no dependencies; used by mnpt_ctrl, mnpt_datapath and the top level
`default_nettype none

package mnpt_pkg;

    localparam int MAX_HELD_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int KEY_W      = 7;
    localparam int CMD_W      = 2;
    localparam int OUT_TIME_W = 32;

    // event command codes
    localparam logic [CMD_W-1:0] CMD_OFF_KEY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFF_VEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ON_KEY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ON_VEL  = 2'd3;

    // table read address select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_SKIP = 2'd2;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       search_step;
        logic       set_vel;
        logic       emit;
        logic       shift_step;
        logic       shrink;
        logic [1:0] rd_sel;
    } ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic more;
    } stat_t;

endpackage

`default_nettype wire

// File: hdl/mnpt_ctrl.sv
// sequencing state machine for the midi note pairing table
// depends on mnpt_pkg; drives mnpt_datapath through ctl_t and reads stat_t
`default_nettype none

module mnpt_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mnpt_pkg::CMD_W-1:0]  cmd,
    input  wire mnpt_pkg::stat_t             stat,
    output mnpt_pkg::ctl_t                   ctl,
    output logic                             busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_APPEND = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_SHIFT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       op_off_reg;
    logic       op_off_next;

    always_comb
    begin
        state_next  = state_reg;
        op_off_next = op_off_reg;
        ctl         = '0;
        ctl.rd_sel  = mnpt_pkg::RD_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    case (cmd)
                        mnpt_pkg::CMD_ON_KEY:
                        begin
                            // a full table drops the note-on
                            if (!stat.full)
                                state_next = ST_APPEND;
                        end
                        mnpt_pkg::CMD_OFF_KEY:
                        begin
                            op_off_next = 1'b1;
                            if (!stat.empty)
                                state_next = ST_SEARCH;
                        end
                        mnpt_pkg::CMD_ON_VEL:
                        begin
                            op_off_next = 1'b0;
                            if (!stat.empty)
                                state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_APPEND:
            begin
                ctl.append = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (stat.match)
                begin
                    if (op_off_reg)
                    begin
                        ctl.emit   = 1'b1;
                        ctl.rd_sel = mnpt_pkg::RD_NEXT;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        ctl.set_vel = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (stat.more)
                begin
                    ctl.search_step = 1'b1;
                    ctl.rd_sel      = mnpt_pkg::RD_NEXT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                // read runs one entry ahead of the write
                if (stat.more)
                begin
                    ctl.shift_step = 1'b1;
                    ctl.rd_sel     = mnpt_pkg::RD_SKIP;
                end
                else
                begin
                    ctl.shrink = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_off_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_off_reg <= op_off_next;
        end
    end

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !stat.empty)
        else $error("search running on an empty table");

    a_emit_only_off: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (op_off_reg && state_reg == ST_SEARCH))
        else $error("note emitted outside a note-off search");

endmodule

`default_nettype wire

// File: hdl/mnpt_datapath.sv
// held-note table, counters and result registers for the midi note pairing table
// depends on mnpt_pkg; commanded by mnpt_ctrl
`default_nettype none

module mnpt_datapath
#(
    parameter int MAX_HELD  = mnpt_pkg::MAX_HELD_DEF,
    parameter int TIME_BITS = mnpt_pkg::TIME_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [mnpt_pkg::CMD_W-1:0]       cmd,
    input  wire logic [mnpt_pkg::KEY_W-1:0]       value,
    input  wire logic [mnpt_pkg::OUT_TIME_W-1:0]  now_time,
    input  wire mnpt_pkg::ctl_t                   ctl,
    output mnpt_pkg::stat_t                       stat,
    output logic                                  done,
    output logic [mnpt_pkg::KEY_W-1:0]            note_key,
    output logic [mnpt_pkg::KEY_W-1:0]            note_velocity,
    output logic [mnpt_pkg::OUT_TIME_W-1:0]       start_time,
    output logic [mnpt_pkg::OUT_TIME_W-1:0]       end_time
);

    localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int CNT_W = $clog2(MAX_HELD + 1);
    localparam int EXT_W = (TIME_BITS > mnpt_pkg::OUT_TIME_W) ? TIME_BITS
                                                               : mnpt_pkg::OUT_TIME_W;

    logic [mnpt_pkg::KEY_W-1:0] key_mem  [MAX_HELD];
    logic [mnpt_pkg::KEY_W-1:0] vel_mem  [MAX_HELD];
    logic [TIME_BITS-1:0]       time_mem [MAX_HELD];

    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [mnpt_pkg::KEY_W-1:0] last_key_reg;
    logic [mnpt_pkg::KEY_W-1:0] skey_reg;
    logic [mnpt_pkg::KEY_W-1:0] val_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic [mnpt_pkg::KEY_W-1:0] rd_key_reg;
    logic [mnpt_pkg::KEY_W-1:0] rd_vel_reg;
    logic [TIME_BITS-1:0]       rd_time_reg;
    logic                       done_reg;

    logic [CNT_W:0]             idx_p1;
    logic [CNT_W:0]             idx_p2;
    logic [IDX_W-1:0]           rd_addr;
    logic                       mem_we;
    logic [IDX_W-1:0]           wr_addr;
    logic [mnpt_pkg::KEY_W-1:0] wr_key;
    logic [mnpt_pkg::KEY_W-1:0] wr_vel;
    logic [TIME_BITS-1:0]       wr_time;
    logic [EXT_W-1:0]           now_ext;
    logic [EXT_W-1:0]           start_ext;
    logic [EXT_W-1:0]           end_ext;

    assign idx_p1 = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign idx_p2 = {1'b0, idx_reg} + (CNT_W + 1)'(2);

    always_comb
    begin
        case (ctl.rd_sel)
            mnpt_pkg::RD_NEXT: rd_addr = idx_p1[IDX_W-1:0];
            mnpt_pkg::RD_SKIP: rd_addr = idx_p2[IDX_W-1:0];
            default:           rd_addr = '0;
        endcase
    end

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_key  = rd_key_reg;
        wr_vel  = rd_vel_reg;
        wr_time = rd_time_reg;
        if (ctl.append)
        begin
            mem_we  = 1'b1;
            wr_addr = cnt_reg[IDX_W-1:0];
            wr_key  = val_reg;
            wr_vel  = '0;
            wr_time = now_reg;
        end
        else if (ctl.set_vel)
        begin
            mem_we = 1'b1;
            wr_vel = val_reg;
        end
        else if (ctl.shift_step)
        begin
            // entry one above the write index closes the gap
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr]  <= wr_key;
            vel_mem[wr_addr]  <= wr_vel;
            time_mem[wr_addr] <= wr_time;
        end
        rd_key_reg  <= key_mem[rd_addr];
        rd_vel_reg  <= vel_mem[rd_addr];
        rd_time_reg <= time_mem[rd_addr];
    end

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(MAX_HELD));
    assign stat.match = (rd_key_reg == skey_reg);
    assign stat.more  = (idx_p1 < {1'b0, cnt_reg});

    assign now_ext   = EXT_W'(now_time);
    assign start_ext = EXT_W'(rd_time_reg);
    assign end_ext   = EXT_W'(now_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            idx_reg      <= '0;
            last_key_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
            if (ctl.load)
                idx_reg <= '0;
            else if (ctl.search_step || ctl.shift_step)
                idx_reg <= idx_p1[CNT_W-1:0];
            if (ctl.append)
            begin
                cnt_reg      <= cnt_reg + CNT_W'(1);
                last_key_reg <= val_reg;
            end
            else if (ctl.shrink)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            skey_reg <= (cmd == mnpt_pkg::CMD_OFF_KEY) ? value : last_key_reg;
            val_reg  <= value;
            now_reg  <= now_ext[TIME_BITS-1:0];
        end
        if (ctl.emit)
        begin
            note_key      <= skey_reg;
            note_velocity <= rd_vel_reg;
            start_time    <= start_ext[mnpt_pkg::OUT_TIME_W-1:0];
            end_time      <= end_ext[mnpt_pkg::OUT_TIME_W-1:0];
        end
    end

    assign done = done_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_HELD))
        else $error("held count above table depth");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_shrink_one: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shrink |=> (cnt_reg == CNT_W'($past(cnt_reg) - CNT_W'(1))))
        else $error("note-off did not remove exactly one entry");

endmodule

`default_nettype wire

// File: hdl/midi_note_pairing_table_unit.sv
// steps: a note-on key appends; a note-on velocity searches for the last key; a note-off
// searches, then shifts the later entries down; done pulses the cycle after the match
// throughput: one event at a time, set by the single read and write port
// of the held-note table (one entry per cycle)
// reset: async, clears state, count and last key; table contents undefined until written
// results are shown for one cycle on done; the receiver cannot stall
`default_nettype none

module midi_note_pairing_table_unit
#(
    parameter int MAX_HELD  = mnpt_pkg::MAX_HELD_DEF,
    parameter int TIME_BITS = mnpt_pkg::TIME_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [mnpt_pkg::CMD_W-1:0]       cmd,
    input  wire logic [mnpt_pkg::KEY_W-1:0]       value,
    input  wire logic [mnpt_pkg::OUT_TIME_W-1:0]  now_time,
    output logic                                  busy,
    output logic                                  done,
    output logic [mnpt_pkg::KEY_W-1:0]            note_key,
    output logic [mnpt_pkg::KEY_W-1:0]            note_velocity,
    output logic [mnpt_pkg::OUT_TIME_W-1:0]       start_time,
    output logic [mnpt_pkg::OUT_TIME_W-1:0]       end_time
);

    mnpt_pkg::ctl_t  ctl;
    mnpt_pkg::stat_t stat;

    mnpt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    mnpt_datapath
    #(
        .MAX_HELD  (MAX_HELD),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (value),
        .now_time      (now_time),
        .ctl           (ctl),
        .stat          (stat),
        .done          (done),
        .note_key      (note_key),
        .note_velocity (note_velocity),
        .start_time    (start_time),
        .end_time      (end_time)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for midi_note_pairing_table_unit
// depends on hdl/mnpt_pkg.sv and hdl/midi_note_pairing_table_unit.sv
// predicts finished notes from each event transfer and checks every done strobe
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_HELD     = mnpt_pkg::MAX_HELD_DEF;
    localparam int DRAIN_CYCLES = 2 * MAX_HELD + 32;
    localparam int RANDOM_NOTES = 650;

    typedef struct {
        logic [mnpt_pkg::KEY_W-1:0]      key;
        logic [mnpt_pkg::KEY_W-1:0]      vel;
        logic [mnpt_pkg::OUT_TIME_W-1:0] t_on;
        logic [mnpt_pkg::OUT_TIME_W-1:0] t_off;
    } note_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            start    = 1'b0;
    logic [mnpt_pkg::CMD_W-1:0]      cmd      = mnpt_pkg::CMD_OFF_KEY;
    logic [mnpt_pkg::KEY_W-1:0]      value    = '0;
    logic [mnpt_pkg::OUT_TIME_W-1:0] now_time = '0;
    wire                             busy;
    wire                             done;
    wire [mnpt_pkg::KEY_W-1:0]       note_key;
    wire [mnpt_pkg::KEY_W-1:0]       note_velocity;
    wire [mnpt_pkg::OUT_TIME_W-1:0]  start_time;
    wire [mnpt_pkg::OUT_TIME_W-1:0]  end_time;

    // predicted contents of the held-note table
    logic [mnpt_pkg::KEY_W-1:0]      held_key_copy   [MAX_HELD];
    logic [mnpt_pkg::KEY_W-1:0]      held_vel_copy   [MAX_HELD];
    logic [mnpt_pkg::OUT_TIME_W-1:0] held_stamp_copy [MAX_HELD];
    int                              held_total      = 0;
    logic [mnpt_pkg::KEY_W-1:0]      last_on_copy    = '0;

    note_t                           pending_notes[$];
    int                              errors          = 0;
    int                              burst_left      = 0;
    bit                              gaps_on         = 1'b1;
    logic [mnpt_pkg::OUT_TIME_W-1:0] clock_stamp     = '0;

    midi_note_pairing_table_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .value         (value),
        .now_time      (now_time),
        .busy          (busy),
        .done          (done),
        .note_key      (note_key),
        .note_velocity (note_velocity),
        .start_time    (start_time),
        .end_time      (end_time)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("midi_note_pairing_table_unit test failed");
        $finish;
    end

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 30)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic int oldest_held(input logic [mnpt_pkg::KEY_W-1:0] key);
        int i;
        for (i = 0; i < held_total; i++)
        begin
            if (held_key_copy[i] == key)
                return i;
        end
        return held_total;
    endfunction

    // update the table copy; returns 1 when the event changed state or made a note
    function automatic bit pair_event(input logic [mnpt_pkg::CMD_W-1:0] c,
                                      input logic [mnpt_pkg::KEY_W-1:0] v,
                                      input logic [mnpt_pkg::OUT_TIME_W-1:0] stamp);
        int    idx;
        int    j;
        note_t n;
        bit    effective;
        effective = 1'b0;
        case (c)
            mnpt_pkg::CMD_OFF_KEY:
            begin
                idx = oldest_held(v);
                if (idx < held_total)
                begin
                    n.key   = v;
                    n.vel   = held_vel_copy[idx];
                    n.t_on  = held_stamp_copy[idx];
                    n.t_off = stamp;
                    pending_notes.push_back(n);
                    for (j = idx; j + 1 < held_total; j++)
                    begin
                        held_key_copy[j]   = held_key_copy[j + 1];
                        held_vel_copy[j]   = held_vel_copy[j + 1];
                        held_stamp_copy[j] = held_stamp_copy[j + 1];
                    end
                    held_total--;
                    effective = 1'b1;
                end
            end
            mnpt_pkg::CMD_ON_KEY:
            begin
                if (held_total < MAX_HELD)
                begin
                    held_key_copy[held_total]   = v;
                    held_vel_copy[held_total]   = '0;
                    held_stamp_copy[held_total] = stamp;
                    held_total++;
                    last_on_copy = v;
                    effective = 1'b1;
                end
            end
            mnpt_pkg::CMD_ON_VEL:
            begin
                idx = oldest_held(last_on_copy);
                if (idx < held_total)
                begin
                    held_vel_copy[idx] = v;
                    effective = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return effective;
    endfunction

    function automatic logic [mnpt_pkg::OUT_TIME_W-1:0] next_stamp();
        if ($urandom_range(0, 19) == 0)
            clock_stamp = $urandom;
        else
            clock_stamp = clock_stamp + $urandom_range(1, 5000);
        return clock_stamp;
    endfunction

    // one event transfer, with bursts and random gaps on the sending side
    task automatic send_event(input logic [mnpt_pkg::CMD_W-1:0] c,
                              input logic [mnpt_pkg::KEY_W-1:0] v,
                              input logic [mnpt_pkg::OUT_TIME_W-1:0] stamp,
                              output bit effective);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        burst_left--;
        @(posedge clk);
        start    <= 1'b1;
        cmd      <= c;
        value    <= v;
        now_time <= stamp;
        do
            @(posedge clk);
        while (busy);
        start <= 1'b0;
        effective = pair_event(c, v, stamp);
    endtask

    task automatic wait_for_notes();
        while (pending_notes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : note_check
        note_t want;
        if (rst_n && done)
        begin
            if (pending_notes.size() == 0)
                report_error($sformatf("unexpected note key %0d", note_key));
            else
            begin
                want = pending_notes.pop_front();
                if (note_key !== want.key)
                    report_error($sformatf("key %0d, want %0d", note_key, want.key));
                if (note_velocity !== want.vel)
                    report_error($sformatf("velocity %0d, want %0d", note_velocity, want.vel));
                if (start_time !== want.t_on)
                    report_error($sformatf("start_time %h, want %h", start_time, want.t_on));
                if (end_time !== want.t_off)
                    report_error($sformatf("end_time %h, want %h", end_time, want.t_off));
            end
        end
    end

    task automatic test_after_reset();
        bit eff;
        // nothing held yet: velocity, note-off and note-off velocity all do nothing
        send_event(mnpt_pkg::CMD_ON_VEL, 7'd100, next_stamp(), eff);
        send_event(mnpt_pkg::CMD_OFF_KEY, 7'd0, next_stamp(), eff);
        send_event(mnpt_pkg::CMD_OFF_VEL, 7'd55, next_stamp(), eff);
    endtask

    task automatic test_extreme_fields();
        bit eff;
        send_event(mnpt_pkg::CMD_ON_KEY, 7'd127, 32'hFFFF_FFFF, eff);
        send_event(mnpt_pkg::CMD_ON_VEL, 7'd127, 32'hFFFF_FFFF, eff);
        send_event(mnpt_pkg::CMD_ON_KEY, 7'd0, 32'h0000_0000, eff);
        send_event(mnpt_pkg::CMD_OFF_KEY, 7'd127, 32'h0000_0000, eff);
    endtask

    task automatic test_duplicate_keys();
        bit eff;
        // velocity and note-off both pick the older of two equal keys
        send_event(mnpt_pkg::CMD_ON_KEY, 7'd5, 32'd1000, eff);
        send_event(mnpt_pkg::CMD_ON_KEY, 7'd5, 32'd2000, eff);
        send_event(mnpt_pkg::CMD_ON_VEL, 7'h55, 32'd2500, eff);
        send_event(mnpt_pkg::CMD_OFF_KEY, 7'd5, 32'd3000, eff);
    endtask

    task automatic test_full_table();
        bit eff;
        while (held_total < MAX_HELD)
            send_event(mnpt_pkg::CMD_ON_KEY, 7'(20 + held_total), next_stamp(), eff);
        // dropped on a full table, so the last key stays the previous one
        send_event(mnpt_pkg::CMD_ON_KEY, 7'd99, next_stamp(), eff);
        send_event(mnpt_pkg::CMD_ON_VEL, 7'd42, next_stamp(), eff);
        send_event(mnpt_pkg::CMD_OFF_KEY, 7'd99, next_stamp(), eff);
    endtask

    task automatic test_pause_until_drained();
        bit eff;
        send_event(mnpt_pkg::CMD_OFF_KEY, held_key_copy[0], next_stamp(), eff);
        wait_for_notes();
    endtask

    function automatic logic [mnpt_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd127;
            2, 3: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(60, 67));
        endcase
    endfunction

    task automatic test_random_traffic();
        int                         notes;
        int                         roll;
        int                         fill_bias;
        bit                         eff;
        logic [mnpt_pkg::KEY_W-1:0] k;
        notes     = 0;
        fill_bias = 60;
        while (notes < RANDOM_NOTES)
        begin
            if ($urandom_range(0, 59) == 0)
                fill_bias = $urandom_range(25, 85);
            if ($urandom_range(0, 79) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 199) == 0)
                wait_for_notes();
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                send_event(mnpt_pkg::CMD_W'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                           $urandom, eff);
                notes++;
            end
            else if (roll < 12 + (88 * fill_bias) / 100)
            begin
                send_event(mnpt_pkg::CMD_ON_KEY, pick_key(), next_stamp(), eff);
                notes++;
                if ($urandom_range(0, 3) != 0)
                begin
                    send_event(mnpt_pkg::CMD_ON_VEL, 7'($urandom_range(0, 127)),
                               next_stamp(), eff);
                    notes++;
                end
            end
            else
            begin
                if (held_total > 0 && $urandom_range(0, 9) != 0)
                    k = held_key_copy[$urandom_range(0, held_total - 1)];
                else
                    k = pick_key();
                send_event(mnpt_pkg::CMD_OFF_KEY, k, next_stamp(), eff);
                notes++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_extreme_fields();
        test_duplicate_keys();
        test_full_table();
        test_pause_until_drained();
        test_random_traffic();
        wait_for_notes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_notes.size() != 0)
            report_error($sformatf("%0d notes never came out", pending_notes.size()));
        if (errors == 0)
            $display("midi_note_pairing_table_unit test passed");
        else
            $display("midi_note_pairing_table_unit test failed");
        $finish;
    end

endmodule
